FILE: hdl/ugbs_pkg.sv
package ugbs_pkg;

	// Default sizes of the line buffer, the plane and the block, and the value width
	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;
	localparam int unsigned MAX_SCALE_DEF  = 8;
	localparam int unsigned VALUE_BITS_DEF = 32;

	// Configuration register widths
	localparam int unsigned IN_WIDTH_BITS  = 11;
	localparam int unsigned IN_HEIGHT_BITS = 13;
	localparam int unsigned SCALE_BITS     = 4;
	localparam int unsigned CFG_DATA_BITS  = 13;
	localparam int unsigned CFG_INDEX_BITS = 2;

	// Configuration register reset values
	localparam logic [IN_WIDTH_BITS-1:0]  IN_WIDTH_RST  = IN_WIDTH_BITS'(16);
	localparam logic [IN_HEIGHT_BITS-1:0] IN_HEIGHT_RST = IN_HEIGHT_BITS'(16);
	localparam logic [SCALE_BITS-1:0]     SCALE_RST     = SCALE_BITS'(2);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IN_WIDTH  = 2'd0,
		REG_IN_HEIGHT = 2'd1,
		REG_SCALE     = 2'd2
	} cfg_reg_t;

endpackage

FILE: hdl/ugbs_ram.sv
module ugbs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; a read of the address being
	// written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/upsample_gradient_block_sum_top.sv
// Backward pass of nearest-neighbor upsampling. Gradient words of the upsampled
// plane stream in raster order, planes back to back, and every completed
// scale-by-scale block leaves as one signed sum with row_end and plane_end
// marks. The block takes one word per clock cycle while in_stall is low: the
// running column sums live in a one-read, one-write RAM of MAX_WIDTH words, read
// when a word is accepted and written back the cycle after, with a bypass for a
// block that continues in the same column. A result passes the stage 1 registers
// and the result queue before it is offered. Results wait in a two-entry queue,
// so input keeps flowing while a result is held up; in_stall rises only when
// that queue is about to fill. in_width, in_height and scale must be written
// through the configuration port only while no transaction is in flight, which
// the block does not enforce; zero acts as one, beyond the maxima as the maximum.
module upsample_gradient_block_sum_top
	import ugbs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int unsigned MAX_SCALE  = MAX_SCALE_DEF,
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	localparam int unsigned SUB_BITS  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1,
	localparam int unsigned SUM_BITS  = VALUE_BITS + 2 * $clog2(MAX_SCALE)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// gradient input
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] grad_value,
	// block sums
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [SUM_BITS-1:0]   block_sum,
	output logic                         row_end,
	output logic                         plane_end,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int unsigned COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum;
		logic                       row_end;
		logic                       plane_end;
	} result_t;

	// Configuration registers
	logic [IN_WIDTH_BITS-1:0]  in_width_q;
	logic [IN_HEIGHT_BITS-1:0] in_height_q;
	logic [SCALE_BITS-1:0]     scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= IN_WIDTH_RST;
			in_height_q <= IN_HEIGHT_RST;
			scale_q     <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IN_WIDTH:  in_width_q  <= cfg_data[IN_WIDTH_BITS-1:0];
				REG_IN_HEIGHT: in_height_q <= cfg_data[IN_HEIGHT_BITS-1:0];
				REG_SCALE:     scale_q     <= cfg_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Last counter values after clamping each register to 1..max
	logic [COL_BITS-1:0] last_col_idx;
	logic [ROW_BITS-1:0] last_row_idx;
	logic [SUB_BITS-1:0] last_sub_idx;

	always_comb begin
		if (in_width_q == '0) begin
			last_col_idx = '0;
		end else if (in_width_q > MAX_WIDTH) begin
			last_col_idx = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			last_col_idx = COL_BITS'(in_width_q - 1'b1);
		end
		if (in_height_q == '0) begin
			last_row_idx = '0;
		end else if (in_height_q > MAX_HEIGHT) begin
			last_row_idx = ROW_BITS'(MAX_HEIGHT - 1);
		end else begin
			last_row_idx = ROW_BITS'(in_height_q - 1'b1);
		end
		if (scale_q == '0) begin
			last_sub_idx = '0;
		end else if (scale_q > MAX_SCALE) begin
			last_sub_idx = SUB_BITS'(MAX_SCALE - 1);
		end else begin
			last_sub_idx = SUB_BITS'(scale_q - 1'b1);
		end
	end

	// Position counters
	logic [SUB_BITS-1:0] sub_col_q, sub_row_q;
	logic [COL_BITS-1:0] low_col_q;
	logic [ROW_BITS-1:0] low_row_q;
	logic                is_last_sub_col, is_last_sub_row, is_last_col, is_last_row;
	logic                in_accept;

	assign in_accept       = in_valid && !in_stall;
	assign is_last_sub_col = sub_col_q >= last_sub_idx;
	assign is_last_sub_row = sub_row_q >= last_sub_idx;
	assign is_last_col     = low_col_q >= last_col_idx;
	assign is_last_row     = low_row_q >= last_row_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_col_q <= '0;
			sub_row_q <= '0;
			low_col_q <= '0;
			low_row_q <= '0;
		end else if (in_accept) begin
			if (!is_last_sub_col) begin
				sub_col_q <= sub_col_q + 1'b1;
			end else begin
				sub_col_q <= '0;
				if (!is_last_col) begin
					low_col_q <= low_col_q + 1'b1;
				end else begin
					low_col_q <= '0;
					if (!is_last_sub_row) begin
						sub_row_q <= sub_row_q + 1'b1;
					end else begin
						sub_row_q <= '0;
						low_row_q <= is_last_row ? '0 : low_row_q + 1'b1;
					end
				end
			end
		end
	end

	// Stage 1: column sum read back, add, write back
	logic                         v_s1;
	logic signed [VALUE_BITS-1:0] grad_s1;
	logic [COL_BITS-1:0]          col_s1;
	logic                         start_s1, emit_s1, row_end_s1, plane_end_s1;
	logic                         fwd_hit_s1;
	logic signed [SUM_BITS-1:0]   fwd_sum_s1;
	logic [SUM_BITS-1:0]          ram_rdata;
	logic signed [SUM_BITS-1:0]   base_sum, new_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			grad_s1      <= grad_value;
			col_s1       <= low_col_q;
			start_s1     <= (sub_col_q == '0) && (sub_row_q == '0);
			emit_s1      <= is_last_sub_col && is_last_sub_row;
			row_end_s1   <= is_last_col;
			plane_end_s1 <= is_last_col && is_last_row;
			// the RAM returns the old word when the write lands on this edge
			fwd_hit_s1   <= v_s1 && (col_s1 == low_col_q);
			fwd_sum_s1   <= new_sum;
		end
	end

	assign base_sum = fwd_hit_s1 ? fwd_sum_s1 : $signed(ram_rdata);
	assign new_sum  = start_s1 ? SUM_BITS'(grad_s1) : base_sum + SUM_BITS'(grad_s1);

	ugbs_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (MAX_WIDTH)
	) u_col_sums (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (new_sum),
		.re    (in_accept),
		.raddr (low_col_q),
		.rdata (ram_rdata)
	);

	// Two-entry result queue
	result_t          res_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push, pop;
	logic [2:0]       cnt_after;

	assign push      = v_s1 && emit_s1;
	assign pop       = out_valid && !out_stall;
	assign cnt_after = 3'(cnt_q) + 3'(push) - 3'(pop);
	// a word taken now may push one more result next cycle
	assign in_stall  = cnt_after > 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_after[1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= '{sum: new_sum, row_end: row_end_s1, plane_end: plane_end_s1};
		end
	end

	assign out_valid = cnt_q != '0;
	assign block_sum = res_q[rd_ptr_q].sum;
	assign row_end   = res_q[rd_ptr_q].row_end;
	assign plane_end = res_q[rd_ptr_q].plane_end;

endmodule

FILE: test/upsample_gradient_block_sum_top_tb.sv
module upsample_gradient_block_sum_top_tb;
	import ugbs_pkg::*;

	localparam int unsigned SUM_W     = VALUE_BITS_DEF + 2 * $clog2(MAX_SCALE_DEF);
	localparam int unsigned LIMIT     = 300000;
	localparam int unsigned SETTLE    = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 2'd3;

	typedef enum {WORDS_RANDOM, WORDS_MAX, WORDS_MIN, WORDS_CORNER} word_mix_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             row_end;
		logic             plane_end;
	} block_result_t;

	// DUT connections
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic signed [VALUE_BITS_DEF-1:0] grad_value = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic signed [SUM_W-1:0]         block_sum;
	logic                            row_end;
	logic                            plane_end;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [CFG_INDEX_BITS-1:0]       cfg_index = REG_IN_WIDTH;
	logic [CFG_DATA_BITS-1:0]        cfg_data = '0;

	// Gradient words waiting to be driven, and block sums waiting to come out
	logic [VALUE_BITS_DEF-1:0] grad_queue[$];
	block_result_t             sums_due[$];

	// Handshake bookkeeping
	logic        in_fire = 1'b0;
	logic        cfg_fire = 1'b0;
	int unsigned in_count = 0;
	int unsigned words_sent = 0;
	int unsigned bad_sums = 0;
	int unsigned cycles = 0;
	logic        calm;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	block_result_t got, want;

	// Shadow of the block: registers, line of column sums, position counters
	logic [IN_WIDTH_BITS-1:0]  cfg_w = IN_WIDTH_RST;
	logic [IN_HEIGHT_BITS-1:0] cfg_h = IN_HEIGHT_RST;
	logic [SCALE_BITS-1:0]     cfg_s = SCALE_RST;
	logic [SUM_W-1:0]          col_sums[MAX_WIDTH_DEF];
	logic [2:0]                sub_c = '0;
	logic [2:0]                sub_r = '0;
	logic [9:0]                lo_c = '0;
	logic [11:0]               lo_r = '0;

	// no idling while this stretch of input transactions goes through
	assign calm = in_count >= 200 && in_count < 600;

	upsample_gradient_block_sum_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.grad_value(grad_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.block_sum (block_sum),
		.row_end   (row_end),
		.plane_end (plane_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// zero acts as one, beyond the maximum acts as the maximum
	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Add one gradient word into its column; queue the block sum when a block closes
	function automatic void sum_block(input logic [VALUE_BITS_DEF-1:0] g);
		int unsigned w, h, s;
		logic [SUM_W-1:0] v;
		logic last_sc, last_sr, last_c, last_r;
		w = clamp_reg(cfg_w, MAX_WIDTH_DEF);
		h = clamp_reg(cfg_h, MAX_HEIGHT_DEF);
		s = clamp_reg(cfg_s, MAX_SCALE_DEF);
		v = {{(SUM_W - VALUE_BITS_DEF){g[VALUE_BITS_DEF-1]}}, g};
		last_sc = sub_c >= s - 1;
		last_sr = sub_r >= s - 1;
		last_c  = lo_c >= w - 1;
		last_r  = lo_r >= h - 1;

		// first word of a block starts the sum afresh
		if (sub_r == 0 && sub_c == 0)
			col_sums[lo_c] = v;
		else
			col_sums[lo_c] = col_sums[lo_c] + v;

		if (last_sc && last_sr)
			sums_due.push_back('{col_sums[lo_c], last_c, last_c && last_r});

		// raster walk: sub column, column, sub row, row
		if (!last_sc) begin
			sub_c = sub_c + 1;
		end else begin
			sub_c = '0;
			if (!last_c) begin
				lo_c = lo_c + 1;
			end else begin
				lo_c = '0;
				if (!last_sr) begin
					sub_r = sub_r + 1;
				end else begin
					sub_r = '0;
					lo_r = last_r ? '0 : lo_r + 1;
				end
			end
		end
	endfunction

	// Edge sampling of all three channels
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[upsample_gradient_block_sum_top] ERROR");
			$finish;
		end else begin
			in_fire  = arst_n && in_valid && !in_stall;
			cfg_fire = arst_n && cfg_valid && cfg_ready;
			if (in_fire) begin
				sum_block(grad_value);
				in_count = in_count + 1;
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_IN_WIDTH:  cfg_w = cfg_data[IN_WIDTH_BITS-1:0];
					REG_IN_HEIGHT: cfg_h = cfg_data[IN_HEIGHT_BITS-1:0];
					REG_SCALE:     cfg_s = cfg_data[SCALE_BITS-1:0];
					default: ;
				endcase
			end
			if (arst_n && out_valid && !out_stall) begin
				got = '{block_sum, row_end, plane_end};
				if (sums_due.size() == 0) begin
					bad_sums = bad_sums + 1;
					if (bad_sums <= 10)
						$display("unexpected block sum: sum=%h row_end=%b plane_end=%b",
							got.sum, got.row_end, got.plane_end);
				end else begin
					want = sums_due.pop_front();
					if (got !== want) begin
						bad_sums = bad_sums + 1;
						if (bad_sums <= 10)
							$display("block sum mismatch: expected sum=%h row_end=%b",
								want.sum, want.row_end,
								" plane_end=%b, got sum=%h", want.plane_end, got.sum,
								" row_end=%b plane_end=%b", got.row_end, got.plane_end);
					end
				end
			end
		end
	end

	// Gradient driver: holds a word until taken, idles now and then
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (grad_queue.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
				in_valid   <= 1'b1;
				grad_value <= grad_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (!hold_done && in_count >= 640) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 7);
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(val);
		do
			@(negedge clk);
		while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	// all words taken, all sums out, then let the pipeline drain
	task automatic wait_idle();
		do
			@(negedge clk);
		while (in_count != words_sent || sums_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// One configuration, then a run of gradient words
	task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
			input int unsigned n, input word_mix_t mix);
		logic [VALUE_BITS_DEF-1:0] corners[8];
		logic [VALUE_BITS_DEF-1:0] g;
		int unsigned k;
		corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000};
		wait_idle();
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_SCALE, s);
		for (k = 0; k < n; k++) begin
			case (mix)
				WORDS_MAX: g = 32'h7FFF_FFFF;
				WORDS_MIN: g = 32'h8000_0000;
				default: begin
					if (mix == WORDS_CORNER && k < 8)
						g = corners[k];
					else
						case ($urandom_range(7))
							0: g = corners[$urandom_range(7)];
							1: g = $urandom_range(32'h3_FFFF) - 32'h2_0000;
							default: g = $urandom;
						endcase
				end
			endcase
			grad_queue.push_back(g);
			words_sent = words_sent + 1;
		end
	endtask

	// Stimulus and verdict
	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// a write to the spare index must leave the registers alone
		write_reg(REG_NONE, 13'h1FFF);
		// wide line first: every column that later blocks continue in gets written
		run_phase(1024, 1, 1, 64, WORDS_CORNER);
		// largest blocks at full scale, both signs
		run_phase(1, 1, 8, 64, WORDS_MAX);
		run_phase(0, 0, 15, 64, WORDS_MIN);
		// assorted shapes, several changed in the middle of a plane
		run_phase(3, 2, 2, 60, WORDS_RANDOM);
		run_phase(5, 3, 3, 100, WORDS_RANDOM);
		run_phase(2047, 8191, 1, 60, WORDS_RANDOM);
		run_phase(13'h1807, 4, 13'h1FF4, 80, WORDS_RANDOM);
		run_phase(16, 16, 2, 80, WORDS_RANDOM);
		run_phase(1, 5, 1, 40, WORDS_RANDOM);
		run_phase(4, 3, 5, 77, WORDS_RANDOM);
		run_phase(2, 2, 3, 50, WORDS_RANDOM);
		run_phase(1024, 4096, 8, 64, WORDS_RANDOM);
		wait_idle();

		if (bad_sums == 0)
			$display("[upsample_gradient_block_sum_top] OK");
		else
			$display("[upsample_gradient_block_sum_top] ERROR");
		$finish;
	end

endmodule
